// ===== hw/rtl/mips_integer_execute_unit_top_defines.svh =====
// Assertion macros for the integer execute unit.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
// Assert that cond implies next-cycle consequence.
`define MIEU_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("mieu check failed");
// Assert that cond implies same-cycle consequence.
`define MIEU_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("mieu check failed");
`endif

// ===== hw/rtl/mieu_pkg.sv =====
// Types and constants of the integer execute unit.
package mieu_pkg;
  localparam logic [4:0] LINK_REGISTER = 5'd31;
  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

  typedef enum logic [2:0] {
    MEM_NONE = 3'd0, MEM_RD_BU = 3'd1, MEM_RD_BS = 3'd2, MEM_RD_W = 3'd3,
    MEM_WR_B = 3'd4, MEM_WR_H = 3'd5, MEM_WR_W = 3'd6
  } mem_op_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0, FLT_OVF = 2'd1, FLT_UNSUP = 2'd2
  } fault_t;

  // load kinds, same encoding as the low bits of the read mem_op codes
  localparam logic [1:0] LD_NONE = 2'd0, LD_BU = 2'd1, LD_BS = 2'd2, LD_W = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_BCOND = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03,
    OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07,
    OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_ANDI = 6'h0C, OP_ORI = 6'h0D,
    OP_LUI = 6'h0F, OP_LB = 6'h20, OP_LW = 6'h23, OP_LBU = 6'h24,
    OP_SB = 6'h28, OP_SH = 6'h29, OP_SW = 6'h2B;
  localparam logic [5:0] FN_SLL = 6'h00, FN_JR = 6'h08, FN_JALR = 6'h09,
    FN_ADD = 6'h20, FN_ADDU = 6'h21, FN_AND = 6'h24, FN_OR = 6'h25, FN_SLTU = 6'h2B,
    FN_UNLISTED = 6'h3F;

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD_DATA = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] instr_word;
    logic [31:0] instr_address;
    logic [31:0] load_data;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic [1:0]  fault;
  } out_beat_t;
endpackage

// ===== hw/rtl/mieu_in_if.sv =====
// Input channel interface.
interface mieu_in_if;
  import mieu_pkg::*;
  logic valid;
  logic ready;
  logic        command;
  logic [31:0] instr_word;
  logic [31:0] instr_address;
  logic [31:0] load_data;
  modport source (output valid, command, instr_word, instr_address, load_data, input ready);
  modport sink (input valid, command, instr_word, instr_address, load_data, output ready);
endinterface

// ===== hw/rtl/mieu_out_if.sv =====
// Result channel interface.
interface mieu_out_if;
  import mieu_pkg::*;
  logic valid;
  logic ready;
  logic [2:0]  mem_op;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;
  logic        branch_taken;
  logic [31:0] branch_target;
  logic [1:0]  fault;
  modport source (output valid, mem_op, mem_addr, mem_wdata, branch_taken, branch_target,
    fault, input ready);
  modport sink (input valid, mem_op, mem_addr, mem_wdata, branch_taken, branch_target,
    fault, output ready);
endinterface

// ===== hw/rtl/mips_integer_execute_unit_top.sv =====
// Top level of the integer execute unit: register file RAM, execute stage, result register.
//  channel | dir | handshake     | payload
//  in      | in  | valid/ready   | command, instr_word, instr_address, load_data
//  out     | out | valid/ready   | mem_op, mem_addr, mem_wdata, branch_taken, branch_target, fault
// One beat per cycle when not stalled: stage 0 reads rs/rt through the two read ports of the
// register RAM, stage 1 executes, writes back and loads the result register.
// A register written in stage 1 is forwarded to a read issued in the same cycle.
// Reset clears the register file, all 32 entries, one entry a cycle, no beat taken then.
// Stage 1 stalls while the result register holds a beat that is not taken, and also
// when its own write and a load delay slot commit to another register coincide.
module mips_integer_execute_unit_top (
  input logic clk,
  input logic rst_n,
  mieu_in_if.sink  in_ch,
  mieu_out_if.source out_ch
);
  import mieu_pkg::*;

  logic [31:0] rf_mem [32];
  logic [31:0] rd_a_r, rd_b_r;
  logic [5:0]  clr_cnt_r;
  logic        clearing;

  logic        s1_valid_r;
  in_beat_t    s1_r;
  logic        s1_fwd_a_r, s1_fwd_b_r;
  logic [31:0] s1_fwd_val_r;

  logic        pl_valid_r, pl_valid_nxt;
  logic [4:0]  pl_reg_r, pl_reg_nxt;
  logic [31:0] pl_val_r, pl_val_nxt;
  logic        aw_valid_r, aw_valid_nxt;
  logic [4:0]  aw_reg_r, aw_reg_nxt;
  logic [1:0]  aw_kind_r, aw_kind_nxt;

  logic        ov_r;
  out_beat_t   ob_r, ob_nxt;

  logic        s1_adv, in_fire, split;
  logic        we;
  logic [4:0]  wa;
  logic [31:0] wd;
  logic        ex_we, ex_pl_commit;
  logic [4:0]  ex_wa;
  logic [31:0] ex_wd;

  assign clearing = !clr_cnt_r[5];
  assign s1_adv   = s1_valid_r && !split && (!ov_r || out_ch.ready);
  assign in_ch.ready = !clearing && (!s1_valid_r || s1_adv);
  assign in_fire  = in_ch.valid && in_ch.ready;

  // execute stage
  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [31:0] a, b, simm, imm, btgt, jtgt, sum;
  logic wr_en;
  logic [4:0] wr_idx;
  logic [31:0] wr_val;
  logic [1:0] new_load;
  logic [31:0] ldv;

  always_comb begin
    op = s1_r.instr_word[31:26];
    rs = s1_r.instr_word[25:21];
    rt = s1_r.instr_word[20:16];
    rd = s1_r.instr_word[15:11];
    sh = s1_r.instr_word[10:6];
    fn = s1_r.instr_word[5:0];
    imm = {16'd0, s1_r.instr_word[15:0]};
    simm = {{16{s1_r.instr_word[15]}}, s1_r.instr_word[15:0]};
    a = (rs == 5'd0) ? 32'd0 : (s1_fwd_a_r ? s1_fwd_val_r : rd_a_r);
    b = (rt == 5'd0) ? 32'd0 : (s1_fwd_b_r ? s1_fwd_val_r : rd_b_r);
    btgt = s1_r.instr_address + 32'd4 + {simm[29:0], 2'b00};
    jtgt = ((s1_r.instr_address + 32'd4) & JUMP_REGION_MASK)
           | {4'd0, s1_r.instr_word[25:0], 2'b00};
    sum = a + ((op == OP_SPECIAL) ? b : simm);
    wr_en = 1'b0; wr_idx = rd; wr_val = 32'd0;
    new_load = LD_NONE;
    ob_nxt = '0;
    pl_valid_nxt = pl_valid_r; pl_reg_nxt = pl_reg_r; pl_val_nxt = pl_val_r;
    aw_valid_nxt = aw_valid_r; aw_reg_nxt = aw_reg_r; aw_kind_nxt = aw_kind_r;
    ldv = 32'd0;
    ex_we = 1'b0; ex_wa = 5'd0; ex_wd = 32'd0;
    ex_pl_commit = 1'b0; split = 1'b0;
    if (s1_r.command == CMD_LOAD_DATA) begin
      unique case (aw_kind_r)
        LD_BU: ldv = {24'd0, s1_r.load_data[7:0]};
        LD_BS: ldv = {{24{s1_r.load_data[7]}}, s1_r.load_data[7:0]};
        default: ldv = s1_r.load_data;
      endcase
      if (aw_valid_r) begin
        pl_valid_nxt = 1'b1; pl_reg_nxt = aw_reg_r; pl_val_nxt = ldv;
        aw_valid_nxt = 1'b0;
      end
    end else begin
      aw_valid_nxt = 1'b0;
      unique case (op)
        OP_SPECIAL: begin
          unique case (fn)
            FN_SLL:  begin wr_en = 1'b1; wr_val = b << sh; end
            FN_JR:   begin ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = a; end
            FN_JALR: begin
              ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = a;
              wr_en = 1'b1; wr_val = s1_r.instr_address + 32'd8;
            end
            FN_ADD: begin
              if ((a[31] ^ sum[31]) & (b[31] ^ sum[31])) ob_nxt.fault = FLT_OVF;
              else begin wr_en = 1'b1; wr_val = sum; end
            end
            FN_ADDU: begin wr_en = 1'b1; wr_val = sum; end
            FN_AND:  begin wr_en = 1'b1; wr_val = a & b; end
            FN_OR:   begin wr_en = 1'b1; wr_val = a | b; end
            FN_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, a < b}; end
            default: ob_nxt.fault = FLT_UNSUP;
          endcase
        end
        OP_J: begin ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = jtgt; end
        OP_JAL: begin
          ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = jtgt;
          wr_en = 1'b1; wr_idx = LINK_REGISTER; wr_val = s1_r.instr_address + 32'd8;
        end
        OP_BEQ: if (a == b) begin ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = btgt; end
        OP_BNE: if (a != b) begin ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = btgt; end
        OP_BLEZ: if (a[31] || a == 32'd0) begin
          ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = btgt;
        end
        OP_BGTZ: if (!a[31] && a != 32'd0) begin
          ob_nxt.branch_taken = 1'b1; ob_nxt.branch_target = btgt;
        end
        OP_ADDI: begin
          wr_idx = rt;
          if ((a[31] ^ sum[31]) & (simm[31] ^ sum[31])) ob_nxt.fault = FLT_OVF;
          else begin wr_en = 1'b1; wr_val = sum; end
        end
        OP_ADDIU: begin wr_idx = rt; wr_en = 1'b1; wr_val = sum; end
        OP_ANDI: begin wr_idx = rt; wr_en = 1'b1; wr_val = a & imm; end
        OP_ORI:  begin wr_idx = rt; wr_en = 1'b1; wr_val = a | imm; end
        OP_LUI:  begin wr_idx = rt; wr_en = 1'b1; wr_val = {imm[15:0], 16'd0}; end
        OP_LB:  new_load = LD_BS;
        OP_LW:  new_load = LD_W;
        OP_LBU: new_load = LD_BU;
        OP_SB: begin
          ob_nxt.mem_op = MEM_WR_B; ob_nxt.mem_addr = sum; ob_nxt.mem_wdata = {24'd0, b[7:0]};
        end
        OP_SH: begin
          ob_nxt.mem_op = MEM_WR_H; ob_nxt.mem_addr = sum; ob_nxt.mem_wdata = {16'd0, b[15:0]};
        end
        OP_SW: begin ob_nxt.mem_op = MEM_WR_W; ob_nxt.mem_addr = sum; ob_nxt.mem_wdata = b; end
        default: ob_nxt.fault = FLT_UNSUP;
      endcase
      // slot commits unless this instruction writes the same register; when both
      // writes are due the slot goes first while stage 1 stalls
      ex_pl_commit = pl_valid_r && (pl_reg_r != 5'd0) && !(wr_en && wr_idx == pl_reg_r);
      if (wr_en && wr_idx != 5'd0) begin
        ex_we = 1'b1; ex_wa = wr_idx; ex_wd = wr_val;
        split = s1_valid_r && ex_pl_commit;
      end else if (ex_pl_commit) begin
        ex_we = 1'b1; ex_wa = pl_reg_r; ex_wd = pl_val_r;
      end
      pl_valid_nxt = 1'b0;
      if (new_load != LD_NONE) begin
        ob_nxt.mem_op = {1'b0, new_load}; ob_nxt.mem_addr = sum; ob_nxt.mem_wdata = 32'd0;
        aw_valid_nxt = 1'b1; aw_reg_nxt = rt; aw_kind_nxt = new_load;
      end
    end
  end

  // register file write port
  always_comb begin
    we = 1'b0; wa = 5'd0; wd = 32'd0;
    if (clearing) begin
      we = 1'b1; wa = clr_cnt_r[4:0];
    end else if (split) begin
      we = 1'b1; wa = pl_reg_r; wd = pl_val_r;
    end else if (s1_adv) begin
      we = ex_we; wa = ex_wa; wd = ex_wd;
    end
  end

  // register file RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) rf_mem[wa] <= wd;
    if (in_fire) begin
      rd_a_r <= rf_mem[in_ch.instr_word[25:21]];
      rd_b_r <= rf_mem[in_ch.instr_word[20:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.command       <= in_ch.command;
      s1_r.instr_word    <= in_ch.instr_word;
      s1_r.instr_address <= in_ch.instr_address;
      s1_r.load_data     <= in_ch.load_data;
      s1_fwd_a_r   <= we && (wa == in_ch.instr_word[25:21]);
      s1_fwd_b_r   <= we && (wa == in_ch.instr_word[20:16]);
      s1_fwd_val_r <= wd;
    end
    if (s1_adv) ob_r <= ob_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      s1_valid_r <= 1'b0;
      ov_r <= 1'b0;
      pl_valid_r <= 1'b0; pl_reg_r <= '0; pl_val_r <= '0;
      aw_valid_r <= 1'b0; aw_reg_r <= '0; aw_kind_r <= '0;
    end else begin
      if (clearing) clr_cnt_r <= clr_cnt_r + 6'd1;
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) begin
        ov_r <= 1'b1;
        pl_valid_r <= pl_valid_nxt; pl_reg_r <= pl_reg_nxt; pl_val_r <= pl_val_nxt;
        aw_valid_r <= aw_valid_nxt; aw_reg_r <= aw_reg_nxt; aw_kind_r <= aw_kind_nxt;
      end else if (out_ch.ready) ov_r <= 1'b0;
      if (split) pl_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.mem_op        = ob_r.mem_op;
  assign out_ch.mem_addr      = ob_r.mem_addr;
  assign out_ch.mem_wdata     = ob_r.mem_wdata;
  assign out_ch.branch_taken  = ob_r.branch_taken;
  assign out_ch.branch_target = ob_r.branch_target;
  assign out_ch.fault         = ob_r.fault;

  logic out_faulted, out_quiet;
  assign out_faulted = out_ch.valid && out_ch.fault != FLT_NONE;
  assign out_quiet   = out_ch.mem_op == MEM_NONE && !out_ch.branch_taken;

  `include "mips_integer_execute_unit_top_defines.svh"
  `MIEU_ASSERT_NOW(a_no_accept_clearing, clearing, !in_ch.ready)
  `MIEU_ASSERT_NOW(a_exec_empties_slot, s1_adv && s1_r.command == CMD_EXEC, !pl_valid_nxt)
  `MIEU_ASSERT_NEXT(a_adv_gives_beat, s1_adv, out_ch.valid)
  `MIEU_ASSERT_NEXT(a_split_clears_slot, split, !pl_valid_r)
  `MIEU_ASSERT_NOW(a_fault_no_request, out_faulted, out_quiet)
endmodule
